@@ rtl/core/piwc_pkg.sv @@
package piwc_pkg;

  localparam int NUM_FACES  = 6;
  localparam int NUM_PAIRS  = 3;
  localparam int NUM_AXES   = 3;
  localparam int FACE_W     = 3;
  localparam int PAIR_W     = 2;

  localparam int POS_W      = 32;
  localparam int CUT_W      = 31;
  localparam int NRM_W      = 18;
  localparam int NRM_PACK_W = NRM_W * NUM_AXES;
  localparam int OFS_W      = 64;
  localparam int OFS_HALF_W = OFS_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Q.28 -> Q20.12 rounding shift
  localparam int RND_SH     = 16;

  localparam int QueueDepthDef = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_XY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_XZ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_YZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_XY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_XZ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_YZ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MASK  = 3'd6;

  localparam logic [NRM_PACK_W-1:0] NORMAL_XY_RST = 54'd4503599627370496;
  localparam logic [NRM_PACK_W-1:0] NORMAL_XZ_RST = 54'd17179869184;
  localparam logic [NRM_PACK_W-1:0] NORMAL_YZ_RST = 54'd65536;
  localparam logic [OFS_W-1:0]      OFFSET_RST    = 64'd17592186044416;

  typedef struct packed {
    logic [NUM_PAIRS-1:0][NRM_PACK_W-1:0] normal;
    logic [NUM_PAIRS-1:0][OFS_W-1:0]      offset;
    logic [NUM_FACES-1:0]                 open_mask;
  } cfg_t;

  // one classified position, front -> back
  typedef struct packed {
    logic                            outside;
    logic [NUM_FACES-1:0]            hit;
    logic [NUM_FACES-1:0][CUT_W-1:0] face_dist;
  } entry_t;

  function automatic logic signed [NRM_W-1:0] nrm_comp(
      input logic [NRM_PACK_W-1:0] v, input int unsigned axis);
    return $signed(v[axis*NRM_W +: NRM_W]);
  endfunction

endpackage

@@ rtl/core/prism_interior_wall_contacts.sv @@
// Path: front input, product and dot registers, the queue, back product and output registers.
// Throughput: one position per cycle into the front pipe unless the queue is full; the result
//   port moves one beat per cycle while popped, max(1, contacts) beats per position, at most six.
// Reset: rst_ni is asynchronous, active low; it empties the pipe, the queue and the output
//   register and loads the default box (unit axes, planes at 0 and 1.0, no open faces).
module prism_interior_wall_contacts #(
  parameter int QUEUE_DEPTH = piwc_pkg::QueueDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // position channel
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [piwc_pkg::POS_W-1:0]     x_pos_i,
  input  logic signed [piwc_pkg::POS_W-1:0]     y_pos_i,
  input  logic signed [piwc_pkg::POS_W-1:0]     z_pos_i,
  input  logic [piwc_pkg::CUT_W-1:0]            cutoff_i,
  // result channel
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  is_inside_o,
  output logic                                  has_contact_o,
  output logic [piwc_pkg::FACE_W-1:0]           face_index_o,
  output logic [piwc_pkg::CUT_W-1:0]            distance_o,
  output logic signed [piwc_pkg::POS_W-1:0]     del_x_o,
  output logic signed [piwc_pkg::POS_W-1:0]     del_y_o,
  output logic signed [piwc_pkg::POS_W-1:0]     del_z_o,
  output logic                                  last_o,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [piwc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [piwc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import piwc_pkg::*;

  // Structure:
  //   front : input register, nine 18x32 products, plane dot products rounded
  //           to Q24.12, then the six face distances, the inside test and the
  //           contact mask. Fully pipelined, stalls only when the queue is full.
  //   queue : a few classified positions, so the front keeps taking beats
  //           while the back is busy emitting contacts.
  //   back  : walks the contact mask of the head entry lowest face first, one
  //           result beat per cycle unless the result port stalls: multiply,
  //           then round/saturate into the output register.

  cfg_t   cfg_q;
  entry_t fq_wdata, fq_rdata;
  logic   fq_push, fq_full, fq_pop, fq_empty;

  // Config registers. Writes to the unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal[0] <= NORMAL_XY_RST;
      cfg_q.normal[1] <= NORMAL_XZ_RST;
      cfg_q.normal[2] <= NORMAL_YZ_RST;
      cfg_q.offset[0] <= OFFSET_RST;
      cfg_q.offset[1] <= OFFSET_RST;
      cfg_q.offset[2] <= OFFSET_RST;
      cfg_q.open_mask <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NORMAL_XY: cfg_q.normal[0] <= cfg_wdata_i[NRM_PACK_W-1:0];
        REG_NORMAL_XZ: cfg_q.normal[1] <= cfg_wdata_i[NRM_PACK_W-1:0];
        REG_NORMAL_YZ: cfg_q.normal[2] <= cfg_wdata_i[NRM_PACK_W-1:0];
        REG_OFFSET_XY: cfg_q.offset[0] <= cfg_wdata_i[OFS_W-1:0];
        REG_OFFSET_XZ: cfg_q.offset[1] <= cfg_wdata_i[OFS_W-1:0];
        REG_OFFSET_YZ: cfg_q.offset[2] <= cfg_wdata_i[OFS_W-1:0];
        REG_OPEN_MASK: cfg_q.open_mask <= cfg_wdata_i[NUM_FACES-1:0];
        default: ;
      endcase
    end
  end

  logic in_ready;
  assign full = !in_ready;

  piwc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (in_ready),
    .x_pos_i    (x_pos_i),
    .y_pos_i    (y_pos_i),
    .z_pos_i    (z_pos_i),
    .cutoff_i   (cutoff_i),
    .cfg_i      (cfg_q),
    .q_push_o   (fq_push),
    .q_data_o   (fq_wdata),
    .q_full_i   (fq_full)
  );

  piwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fq_push),
    .wr_data_i (fq_wdata),
    .full_o    (fq_full),
    .rd_en_i   (fq_pop),
    .rd_data_o (fq_rdata),
    .empty_o   (fq_empty)
  );

  piwc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_data_i      (fq_rdata),
    .q_empty_i     (fq_empty),
    .q_pop_o       (fq_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .is_inside_o   (is_inside_o),
    .has_contact_o (has_contact_o),
    .face_index_o  (face_index_o),
    .distance_o    (distance_o),
    .del_x_o       (del_x_o),
    .del_y_o       (del_y_o),
    .del_z_o       (del_z_o),
    .last_o        (last_o)
  );

endmodule

@@ rtl/core/piwc_front.sv @@
module piwc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [piwc_pkg::POS_W-1:0] x_pos_i,
  input  logic signed [piwc_pkg::POS_W-1:0] y_pos_i,
  input  logic signed [piwc_pkg::POS_W-1:0] z_pos_i,
  input  logic [piwc_pkg::CUT_W-1:0]    cutoff_i,
  input  piwc_pkg::cfg_t                cfg_i,
  output logic                          q_push_o,
  output piwc_pkg::entry_t              q_data_o,
  input  logic                          q_full_i
);
  import piwc_pkg::*;

  localparam int PROD_W = NRM_W + POS_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int DOT_W  = ACC_W - RND_SH;
  localparam int DIST_W = DOT_W + 1;

  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  logic signed [POS_W-1:0]  pos0_q [NUM_AXES];
  logic [CUT_W-1:0]         cut0_q, cut1_q, cut2_q;
  logic signed [PROD_W-1:0] prod1_q [NUM_PAIRS][NUM_AXES];
  logic signed [DOT_W-1:0]  dot2_q [NUM_PAIRS];
  logic signed [DOT_W-1:0]  dot_d  [NUM_PAIRS];
  logic signed [ACC_W-1:0]  acc    [NUM_PAIRS];

  // stall-all pipe: a stage moves when the one after it is free or moving
  assign en2        = !v2_q || !q_full_i;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;
  assign q_push_o   = v2_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      acc[p] = ACC_W'(prod1_q[p][0]) + ACC_W'(prod1_q[p][1]) + ACC_W'(prod1_q[p][2])
             + ACC_W'(1 <<< (RND_SH - 1));
      dot_d[p] = acc[p][ACC_W-1:RND_SH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      pos0_q[0] <= x_pos_i;
      pos0_q[1] <= y_pos_i;
      pos0_q[2] <= z_pos_i;
      cut0_q    <= cutoff_i;
    end
    if (en1) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          prod1_q[p][j] <= nrm_comp(cfg_i.normal[p], j) * pos0_q[j];
        end
      end
      cut1_q <= cut0_q;
    end
    if (en2) begin
      dot2_q <= dot_d;
      cut2_q <= cut1_q;
    end
  end

  // plane distances, inside test and contact mask
  always_comb begin
    logic signed [DIST_W-1:0] d [NUM_FACES];
    logic signed [DIST_W-1:0] cut_s;
    cut_s = $signed({{(DIST_W - CUT_W){1'b0}}, cut2_q});
    for (int p = 0; p < NUM_PAIRS; p++) begin
      d[2*p]   = DIST_W'(dot2_q[p])
               - DIST_W'($signed(cfg_i.offset[p][OFS_HALF_W-1:0]));
      d[2*p+1] = DIST_W'($signed(cfg_i.offset[p][OFS_W-1:OFS_HALF_W]))
               - DIST_W'(dot2_q[p]);
    end
    q_data_o.outside = 1'b0;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (d[f][DIST_W-1]) q_data_o.outside = 1'b1;
      q_data_o.hit[f]       = !cfg_i.open_mask[f] && (d[f] < cut_s);
      q_data_o.face_dist[f] = d[f][CUT_W-1:0];
    end
  end

endmodule

@@ rtl/core/piwc_queue.sv @@
module piwc_queue #(
  parameter int DEPTH = piwc_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  piwc_pkg::entry_t wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output piwc_pkg::entry_t rd_data_o,
  output logic             empty_o
);
  import piwc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

@@ rtl/core/piwc_back.sv @@
module piwc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  piwc_pkg::cfg_t                    cfg_i,
  input  piwc_pkg::entry_t                  q_data_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic                              is_inside_o,
  output logic                              has_contact_o,
  output logic [piwc_pkg::FACE_W-1:0]       face_index_o,
  output logic [piwc_pkg::CUT_W-1:0]        distance_o,
  output logic signed [piwc_pkg::POS_W-1:0] del_x_o,
  output logic signed [piwc_pkg::POS_W-1:0] del_y_o,
  output logic signed [piwc_pkg::POS_W-1:0] del_z_o,
  output logic                              last_o
);
  import piwc_pkg::*;

  localparam int NRMX_W = NRM_W + 1;
  localparam int MUL_W  = POS_W + NRMX_W;
  localparam int RND_W  = MUL_W - RND_SH;

  logic [NUM_FACES-1:0] served_q, served_d;
  logic [NUM_FACES-1:0] pending, onehot, rest;
  logic [FACE_W-1:0]    face;
  logic                 single, fire, en_b1, en_out;

  logic                     b1_v_q, out_v_q;
  logic                     b1_inside_q, b1_contact_q, b1_last_q;
  logic [FACE_W-1:0]        b1_face_q;
  logic [CUT_W-1:0]         b1_dist_q;
  logic signed [MUL_W-1:0]  b1_prod_q [NUM_AXES];
  logic signed [MUL_W-1:0]  prod_d    [NUM_AXES];
  logic signed [POS_W-1:0]  sat_d     [NUM_AXES];
  logic signed [POS_W-1:0]  del_q     [NUM_AXES];

  assign en_out  = !out_v_q || pop_i;
  assign en_b1   = !b1_v_q || en_out;
  assign empty_o = !out_v_q;

  // walk the contact faces of the head entry, lowest face first
  always_comb begin
    pending = q_data_i.hit & ~served_q;
    face    = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (pending[f]) face = FACE_W'(f);
    end
    onehot  = NUM_FACES'(1) << face;
    rest    = pending & ~onehot;
    single  = q_data_i.outside || (q_data_i.hit == '0);
    fire    = !q_empty_i && en_b1;
    q_pop_o = fire && (single || (rest == '0));
    served_d = served_q;
    if (fire) served_d = q_pop_o ? '0 : (served_q | onehot);
  end

  // distance times normal; odd faces use the negated normal
  always_comb begin
    logic signed [NRMX_W-1:0] c;
    logic signed [POS_W-1:0]  d;
    d = $signed({1'b0, q_data_i.face_dist[face]});
    for (int j = 0; j < NUM_AXES; j++) begin
      c = NRMX_W'(nrm_comp(cfg_i.normal[face[FACE_W-1:1]], j));
      if (face[0]) c = -c;
      prod_d[j] = d * c;
    end
  end

  // round to nearest, ties up, then saturate to 32 bits; zero on a beat without contact
  always_comb begin
    logic signed [MUL_W-1:0] s;
    logic signed [RND_W-1:0] r;
    for (int j = 0; j < NUM_AXES; j++) begin
      s = b1_prod_q[j] + MUL_W'(1 <<< (RND_SH - 1));
      r = s[MUL_W-1:RND_SH];
      if (r > RND_W'(signed'({1'b0, {(POS_W-1){1'b1}}}))) begin
        sat_d[j] = {1'b0, {(POS_W-1){1'b1}}};
      end else if (r < RND_W'(signed'({1'b1, {(POS_W-1){1'b0}}}))) begin
        sat_d[j] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        sat_d[j] = r[POS_W-1:0];
      end
      if (!b1_contact_q) sat_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      served_q <= '0;
      b1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      served_q <= served_d;
      if (en_b1)  b1_v_q  <= fire;
      if (en_out) out_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b1) begin
      b1_prod_q <= prod_d;
      if (single) begin
        b1_inside_q  <= !q_data_i.outside;
        b1_contact_q <= 1'b0;
        b1_face_q    <= '0;
        b1_dist_q    <= '0;
        b1_last_q    <= 1'b1;
      end else begin
        b1_inside_q  <= 1'b1;
        b1_contact_q <= 1'b1;
        b1_face_q    <= face;
        b1_dist_q    <= q_data_i.face_dist[face];
        b1_last_q    <= (rest == '0);
      end
    end
    if (en_out) begin
      is_inside_o   <= b1_inside_q;
      has_contact_o <= b1_contact_q;
      face_index_o  <= b1_face_q;
      distance_o    <= b1_dist_q;
      last_o        <= b1_last_q;
      del_q         <= sat_d;
    end
  end

  assign del_x_o = del_q[0];
  assign del_y_o = del_q[1];
  assign del_z_o = del_q[2];

endmodule

@@ rtl/core/piwc_checker.sv @@
module piwc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic                              is_inside_o,
  input logic                              has_contact_o,
  input logic [piwc_pkg::FACE_W-1:0]       face_index_o,
  input logic [piwc_pkg::CUT_W-1:0]        distance_o,
  input logic signed [piwc_pkg::POS_W-1:0] del_x_o,
  input logic signed [piwc_pkg::POS_W-1:0] del_y_o,
  input logic signed [piwc_pkg::POS_W-1:0] del_z_o,
  input logic                              last_o
);
  import piwc_pkg::*;

  logic              open_q;
  logic [FACE_W-1:0] prev_face_q;

  // track a position whose contact beats are still coming
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      prev_face_q <= '0;
    end else if (pop && !empty) begin
      open_q      <= has_contact_o && !last_o;
      prev_face_q <= face_index_o;
    end
  end

  a_contact_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_contact_o) |-> is_inside_o)
    else $error("contact beat for a point outside the box");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_contact_o) |-> (last_o && distance_o == '0 && del_x_o == '0
                                    && del_y_o == '0 && del_z_o == '0))
    else $error("no-contact beat is not a lone zero beat");

  a_face_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && open_q) |-> (has_contact_o && face_index_o > prev_face_q))
    else $error("contact beats out of face order");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(face_index_o) && $stable(distance_o)
                          && $stable(del_x_o) && $stable(last_o)))
    else $error("stalled result beat changed");

endmodule

bind prism_interior_wall_contacts piwc_checker u_checker (.*);
